### rtl/mstq_pkg.sv
// Shared constants, codes, types and index helpers for the timer slot queue.
// No dependencies; every other file but mstq_ram imports this package.
`default_nettype none

package mstq_pkg;

  // Number of timer slots held in the slot memory (1 to 16, the reach of a 4-bit slot id).
  localparam int NUM_SLOTS = 16;

  // Slot memory address width, and a counter width that can hold NUM_SLOTS itself.
  localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_CW = $clog2(NUM_SLOTS + 1);

  localparam int TICK_W   = 32;
  localparam int PERIOD_W = 24;
  localparam int ID_W     = 4;

  // Request codes.
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_REGISTER = 2'd1;
  localparam logic [1:0] REQ_CANCEL   = 2'd2;
  localparam logic [1:0] REQ_CLEAR    = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  // One entry of the slot memory.
  typedef struct packed {
    logic [TICK_W-1:0]   deadline;
    logic [PERIOD_W-1:0] period;
    logic                one_shot;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // Map a request slot id onto a memory address.
  function automatic logic [SLOT_AW-1:0] id_to_addr(input logic [ID_W-1:0] id);
    logic [SLOT_AW+ID_W-1:0] wide;
    wide = {{SLOT_AW{1'b0}}, id};
    return wide[SLOT_AW-1:0];
  endfunction

  // Map a memory address back onto a result slot id.
  function automatic logic [ID_W-1:0] addr_to_id(input logic [SLOT_AW-1:0] addr);
    logic [SLOT_AW+ID_W-1:0] wide;
    wide = {{ID_W{1'b0}}, addr};
    return wide[ID_W-1:0];
  endfunction

  // True when the request slot id names a slot that exists.
  function automatic logic id_in_range(input logic [ID_W-1:0] id);
    return (int'(id) < NUM_SLOTS);
  endfunction

endpackage

`default_nettype wire

### rtl/mstq_if.sv
// Valid/ready channel interfaces for requests and results of the timer slot queue.
// Depends on mstq_pkg for field widths.
`default_nettype none

interface mstq_req_if;
  import mstq_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic [ID_W-1:0]     slot_id;
  logic [PERIOD_W-1:0] period;
  logic                one_shot;

  modport source (output valid, req_type, slot_id, period, one_shot, input ready);
  modport sink   (input valid, req_type, slot_id, period, one_shot, output ready);
endinterface

interface mstq_res_if;
  import mstq_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [ID_W-1:0]   fired_slot;
  logic [TICK_W-1:0] fire_time;
  logic              was_one_shot;
  logic              last;

  modport source (output valid, result_kind, fired_slot, fire_time, was_one_shot, last,
                  input ready);
  modport sink   (input valid, result_kind, fired_slot, fire_time, was_one_shot, last,
                  output ready);
endinterface

`default_nettype wire

### rtl/mstq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module mstq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/multi_slot_timer_queue_unit.sv
// Top level of the timer slot queue: request handling, tick scan and result register.
// Depends on mstq_pkg, mstq_if (mstq_req_if, mstq_res_if) and mstq_ram.
//
// A table of NUM_SLOTS timer slots. Register, cancel and clear requests each give
// exactly one result transaction (last = 1); the next request is taken as soon as
// the result register is free or being emptied. A tick advances the 32-bit wrapping
// time count and then scans every slot in index order, one slot a cycle through the
// slot memory's single read port unless the result side stalls the scan. After the
// tick's accept the block reads each slot, evaluates the last one, sees the scan
// empty and hands over any final expiry before it takes the next request; a stalled
// result side holds it back further. Each armed slot whose deadline equals the new
// time gives one expiry transaction; one-shot slots disarm, repeating slots re-arm
// at time plus period. A tick with no expiry gives no transaction. Deadline, period
// and style live in the slot memory; armed bits are flip-flops cleared by reset and
// by a clear request, so no clearing pass is needed after reset.
`default_nettype none

module multi_slot_timer_queue_unit
  import mstq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  mstq_req_if.sink    req,
  mstq_res_if.source  res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]           state;
  logic [TICK_W-1:0]    cur_tick;
  logic [NUM_SLOTS-1:0] armed;

  // Scan pipeline: read stage index and evaluate stage.
  logic [SLOT_CW-1:0]   idx_rd;
  logic                 ev_valid;
  logic [SLOT_AW-1:0]   ev_idx;

  // Pending expiry, held back until it is known whether another one follows.
  logic                 pend_valid;
  logic [ID_W-1:0]      pend_slot;
  logic                 pend_one_shot;

  // Result register.
  logic                 out_valid;
  logic [1:0]           out_kind;
  logic [ID_W-1:0]      out_slot;
  logic                 out_one_shot;
  logic                 out_last;

  // Memory ports.
  logic                 wr_en;
  logic [SLOT_AW-1:0]   wr_addr;
  slot_entry_t          wr_entry;
  logic [SLOT_AW-1:0]   rd_addr;
  slot_entry_t          rd_entry;
  logic [ENTRY_W-1:0]   rd_bits;

  logic                 out_free;
  logic                 in_acc;
  logic                 rd_more;
  logic                 hit;
  logic                 stall;
  logic                 reg_ok;
  logic [SLOT_AW-1:0]   req_addr;

  assign out_free = !out_valid || res.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign in_acc = req.valid && req.ready;

  assign req_addr = id_to_addr(req.slot_id);
  assign reg_ok   = (req.period != '0) && id_in_range(req.slot_id);

  assign rd_more = (idx_rd < SLOT_CW'(NUM_SLOTS));
  assign rd_entry = slot_entry_t'(rd_bits);
  assign hit   = (state == S_SCAN) && ev_valid && armed[ev_idx]
                 && (rd_entry.deadline == cur_tick);
  // Hold the scan when a second expiry is found and the first cannot move on.
  assign stall = hit && pend_valid && !out_free;

  // Re-read the entry under evaluation while stalled so its data stays put.
  assign rd_addr = stall ? ev_idx : idx_rd[SLOT_AW-1:0];

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = req_addr;
    wr_entry = '{deadline: cur_tick + {{(TICK_W-PERIOD_W){1'b0}}, req.period},
                 period:   req.period,
                 one_shot: req.one_shot};
    if (state == S_SCAN) begin
      // Re-arm a repeating slot at now plus its period.
      wr_en    = hit && !stall && !rd_entry.one_shot;
      wr_addr  = ev_idx;
      wr_entry = '{deadline: cur_tick + {{(TICK_W-PERIOD_W){1'b0}}, rd_entry.period},
                   period:   rd_entry.period,
                   one_shot: rd_entry.one_shot};
    end else if (in_acc && (req.req_type == REQ_REGISTER) && reg_ok) begin
      wr_en = 1'b1;
    end
  end

  mstq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_tick   <= '0;
      armed      <= '0;
      idx_rd     <= '0;
      ev_valid   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Drop the result once taken; overridden below when a new one is loaded.
      if (out_free) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            out_one_shot <= 1'b0;
            out_last     <= 1'b1;
            out_slot     <= req.slot_id;
            out_kind     <= KIND_ACCEPT;
            case (req.req_type)
              REQ_TICK: begin
                cur_tick <= cur_tick + TICK_W'(1);
                idx_rd   <= '0;
                ev_valid <= 1'b0;
                state    <= S_SCAN;
              end
              REQ_REGISTER: begin
                out_valid <= 1'b1;
                if (reg_ok) begin
                  armed[req_addr] <= 1'b1;
                end else begin
                  out_kind <= KIND_REJECT;
                end
              end
              REQ_CANCEL: begin
                out_valid <= 1'b1;
                if (id_in_range(req.slot_id)) begin
                  armed[req_addr] <= 1'b0;
                end
              end
              default: begin
                out_valid <= 1'b1;
                out_slot  <= '0;
                armed     <= '0;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!stall) begin
            ev_valid <= rd_more;
            ev_idx   <= idx_rd[SLOT_AW-1:0];
            if (rd_more) begin
              idx_rd <= idx_rd + SLOT_CW'(1);
            end
            if (hit) begin
              // A later expiry exists, so the held one is not the last.
              if (pend_valid) begin
                out_valid    <= 1'b1;
                out_kind     <= KIND_EXPIRY;
                out_slot     <= pend_slot;
                out_one_shot <= pend_one_shot;
                out_last     <= 1'b0;
              end
              pend_valid    <= 1'b1;
              pend_slot     <= addr_to_id(ev_idx);
              pend_one_shot <= rd_entry.one_shot;
              if (rd_entry.one_shot) begin
                armed[ev_idx] <= 1'b0;
              end
            end
            if (!rd_more && !ev_valid) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid    <= 1'b1;
            out_kind     <= KIND_EXPIRY;
            out_slot     <= pend_slot;
            out_one_shot <= pend_one_shot;
            out_last     <= 1'b1;
            pend_valid   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The time count only moves on a tick accept, which needs a free result
  // register, so a waiting result always sees the time it was produced at.
  assign res.valid        = out_valid;
  assign res.result_kind  = out_kind;
  assign res.fired_slot   = out_slot;
  assign res.fire_time    = cur_tick;
  assign res.was_one_shot = out_one_shot;
  assign res.last         = out_last;

  // No expiry may be left behind once the block is back at rest.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending expiry left over in idle");

  // Only expiries carry a style.
  a_style_on_expiry: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind != KIND_EXPIRY)) |-> !out_one_shot)
    else $error("style set on a non-expiry result");

  // A tick advances the time count by exactly one.
  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (req.req_type == REQ_TICK)) |=>
      (cur_tick == TICK_W'($past(cur_tick) + TICK_W'(1))))
    else $error("time count did not advance on a tick");

  // A one-shot expiry disarms its slot.
  a_one_shot_disarm: assert property (@(posedge clk) disable iff (rst)
    (hit && !stall && rd_entry.one_shot) |=> !armed[$past(ev_idx)])
    else $error("one-shot slot still armed after expiry");

  // The scan never touches the memory for a request write.
  a_scan_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && wr_en) |-> (hit && (wr_addr == ev_idx)))
    else $error("memory write during scan outside a re-arm");

endmodule

`default_nettype wire

### sim/mstq_expiry_checker.sv
`timescale 1ns / 1ps
// Transaction checker for the timer slot queue: keeps its own slot table and works
// out the expiries and request results that each accepted request should give.
// Depends on mstq_pkg and the channel interfaces in mstq_if.
module mstq_expiry_checker
  import mstq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  mstq_req_if       req,
  mstq_res_if       res,
  output int        fail_count,
  output int        outstanding
);

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   slot;
    logic [TICK_W-1:0] stamp;
    logic              one_shot;
    logic              last;
  } timer_result_t;

  timer_result_t       due_results[$];
  logic [TICK_W-1:0]   now_tick;
  logic [NUM_SLOTS-1:0] armed;
  logic [NUM_SLOTS-1:0] fire_once;
  logic [TICK_W-1:0]   deadline [NUM_SLOTS];
  logic [PERIOD_W-1:0] reload [NUM_SLOTS];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic timer_result_t make_result(input logic [1:0] kind,
                                                input logic [ID_W-1:0] slot,
                                                input logic one_shot,
                                                input logic last);
    timer_result_t r;
    r.kind     = kind;
    r.slot     = slot;
    r.stamp    = now_tick;
    r.one_shot = one_shot;
    r.last     = last;
    return r;
  endfunction

  task automatic predict_request(input logic [1:0] kind, input logic [ID_W-1:0] slot,
                                 input logic [PERIOD_W-1:0] ticks, input logic one_shot);
    logic [NUM_SLOTS-1:0] due;
    int top_slot;
    case (kind)
      REQ_TICK: begin
        now_tick = now_tick + 1'b1;
        due      = '0;
        top_slot = -1;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (armed[s] && deadline[s] == now_tick) begin
            due[s]   = 1'b1;
            top_slot = s;
          end
        end
        // Expiries leave in slot order; the highest firing slot closes the tick.
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (due[s]) begin
            due_results.push_back(make_result(KIND_EXPIRY, ID_W'(s), fire_once[s],
                                              s == top_slot));
            if (fire_once[s]) armed[s] = 1'b0;
            else deadline[s] = now_tick + TICK_W'(reload[s]);
          end
        end
      end
      REQ_REGISTER: begin
        if (ticks == '0 || !id_in_range(slot)) begin
          due_results.push_back(make_result(KIND_REJECT, slot, 1'b0, 1'b1));
        end else begin
          armed[int'(slot)]     = 1'b1;
          fire_once[int'(slot)] = one_shot;
          reload[int'(slot)]    = ticks;
          deadline[int'(slot)]  = now_tick + TICK_W'(ticks);
          due_results.push_back(make_result(KIND_ACCEPT, slot, 1'b0, 1'b1));
        end
      end
      REQ_CANCEL: begin
        if (id_in_range(slot)) armed[int'(slot)] = 1'b0;
        due_results.push_back(make_result(KIND_ACCEPT, slot, 1'b0, 1'b1));
      end
      default: begin
        armed = '0;
        due_results.push_back(make_result(KIND_ACCEPT, '0, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [TICK_W-1:0] want,
                               input logic [TICK_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    timer_result_t want;
    if (due_results.size() == 0) begin
      $error("result transaction with nothing expected: kind %0d slot %0d time %0d",
             res.result_kind, res.fired_slot, res.fire_time);
      fail_count++;
    end else begin
      want = due_results.pop_front();
      compare_field("result_kind", TICK_W'(want.kind), TICK_W'(res.result_kind));
      compare_field("fired_slot", TICK_W'(want.slot), TICK_W'(res.fired_slot));
      compare_field("fire_time", want.stamp, res.fire_time);
      compare_field("was_one_shot", TICK_W'(want.one_shot), TICK_W'(res.was_one_shot));
      compare_field("last", TICK_W'(want.last), TICK_W'(res.last));
    end
  endtask

  // Predict before comparing, so a request and a result in the same cycle stay ordered.
  always @(posedge clk) begin
    if (rst) begin
      now_tick = '0;
      armed    = '0;
      due_results.delete();
    end else begin
      if (req.valid === 1'b1 && req.ready === 1'b1)
        predict_request(req.req_type, req.slot_id, req.period, req.one_shot);
      if (res.valid === 1'b1 && res.ready === 1'b1)
        check_result();
    end
    outstanding = due_results.size();
  end

endmodule

### sim/tb_multi_slot_timer_queue_unit.sv
`timescale 1ns / 1ps
// Testbench top for multi_slot_timer_queue_unit: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on mstq_pkg, mstq_if and mstq_expiry_checker.
module tb_multi_slot_timer_queue_unit;
  import mstq_pkg::*;

  localparam int ITEM_TARGET  = 380;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 4 * (NUM_SLOTS + 3);
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst;

  mstq_req_if req_ch ();
  mstq_res_if res_ch ();

  int fail_count;
  int outstanding;
  int items_sent = 0;
  int cycle_count = 0;

  // Flow controls for the request driver and the result receiver, set by the main sequence.
  bit req_steady   = 1'b0;
  bit res_steady   = 1'b0;
  bit hold_results = 1'b0;

  multi_slot_timer_queue_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  mstq_expiry_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .res         (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result receiver. Unless steady, draw a stall for every transaction, hold ready low
  // for it, then take one transaction. On request, hold off for a long stretch first so
  // the block backs up and stalls its request channel.
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = res_steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid === 1'b1 && res_ch.ready === 1'b1));
      @(negedge clk);
    end
  end

  // Offer one request after a drawn gap (none when steady) and hold it until the block takes it.
  // Valid stays high between back-to-back transactions.
  task automatic send_request(input logic [1:0] kind, input logic [ID_W-1:0] slot,
                              input logic [PERIOD_W-1:0] ticks, input logic one_shot);
    int gap;
    gap = req_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.req_type <= kind;
    req_ch.slot_id  <= slot;
    req_ch.period   <= ticks;
    req_ch.one_shot <= one_shot;
    req_ch.valid    <= 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  // Ticks carry random junk in the unused fields; the block must ignore it.
  task automatic send_tick();
    send_request(REQ_TICK, ID_W'($urandom_range(0, 15)), PERIOD_W'($urandom()),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic send_register(input logic [PERIOD_W-1:0] ticks);
    send_request(REQ_REGISTER, ID_W'($urandom_range(0, 15)), ticks,
                 1'($urandom_range(0, 1)));
  endtask

  // Drop valid and hold until every expected result has been taken.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // Arm every slot with one short period, then tick past it: a full burst of expiries.
  task automatic fill_table();
    int ticks;
    ticks = $urandom_range(1, 4);
    for (int s = 0; s < NUM_SLOTS; s++)
      send_request(REQ_REGISTER, ID_W'(s), PERIOD_W'(ticks), 1'($urandom_range(0, 1)));
    repeat (ticks + $urandom_range(0, 2)) send_tick();
  endtask

  // Half well-formed arm-then-tick sequences with random content; the rest is cancels,
  // clears, wide or zero periods, full-table bursts, bare ticks and fully random noise.
  task automatic run_random(input int target);
    int pick;
    logic [PERIOD_W-1:0] wide;
    while (items_sent < target) begin
      req_steady = ($urandom_range(0, 3) == 0);
      res_steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        repeat ($urandom_range(1, 4)) send_register(PERIOD_W'($urandom_range(1, 6)));
        repeat ($urandom_range(1, 8)) send_tick();
      end else if (pick < 62) begin
        send_request(REQ_CANCEL, ID_W'($urandom_range(0, 15)), PERIOD_W'($urandom()),
                     1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 4)) send_tick();
      end else if (pick < 70) begin
        wide = ($urandom_range(0, 2) == 0) ? '0 : PERIOD_W'($urandom());
        send_register(wide);
      end else if (pick < 74) begin
        send_request(REQ_CLEAR, ID_W'($urandom_range(0, 15)), PERIOD_W'($urandom()),
                     1'($urandom_range(0, 1)));
      end else if (pick < 77) begin
        fill_table();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) send_tick();
      end else begin
        repeat ($urandom_range(1, 3))
          send_request(2'($urandom_range(0, 3)), ID_W'($urandom_range(0, 15)),
                       PERIOD_W'($urandom()), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.slot_id  = '0;
    req_ch.period   = '0;
    req_ch.one_shot = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: tick with nothing armed, zero period, longest period, slot order
    // against registration order, repeat and one-shot styles, re-register,
    // cancel of an armed and an idle slot, and clear all.
    send_tick();
    send_request(REQ_REGISTER, ID_W'(0), '0, 1'b0);
    send_request(REQ_REGISTER, ID_W'(15), {PERIOD_W{1'b1}}, 1'b1);
    send_request(REQ_REGISTER, ID_W'(3), PERIOD_W'(1), 1'b1);
    send_request(REQ_REGISTER, ID_W'(5), PERIOD_W'(2), 1'b0);
    send_request(REQ_REGISTER, ID_W'(2), PERIOD_W'(1), 1'b0);
    send_tick();
    send_tick();
    send_request(REQ_REGISTER, ID_W'(5), PERIOD_W'(1), 1'b1);
    send_request(REQ_CANCEL, ID_W'(2), {PERIOD_W{1'b1}}, 1'b1);
    send_request(REQ_CANCEL, ID_W'(7), '0, 1'b0);
    send_tick();
    send_tick();
    send_request(REQ_CANCEL, ID_W'(15), '0, 1'b0);
    send_request(REQ_REGISTER, ID_W'(10), PERIOD_W'(1), 1'b0);
    send_request(REQ_CLEAR, ID_W'(9), PERIOD_W'(3), 1'b1);
    send_tick();
    wait_for_results();

    // Every slot fires on one tick, with both sides running flat out.
    req_steady = 1'b1;
    res_steady = 1'b1;
    fill_table();
    wait_for_results();

    run_random(items_sent + 150);

    // Back-pressure: stop taking results while requests keep coming, so the
    // result register fills and the request channel stalls.
    req_steady   = 1'b1;
    res_steady   = 1'b0;
    hold_results = 1'b1;
    repeat (12) send_register(PERIOD_W'($urandom_range(1, 5)));
    wait_for_results();

    run_random(ITEM_TARGET);

    // Drain, then keep watching for any stray transaction to show up.
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
rtl/mstq_pkg.sv
rtl/mstq_if.sv
rtl/mstq_ram.sv
rtl/multi_slot_timer_queue_unit.sv
sim/mstq_expiry_checker.sv
sim/tb_multi_slot_timer_queue_unit.sv
